/* rtl/ebc_pkg.sv */
// Shared types and constants for the embedding index bounds checker.
package ebc_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned TALLY_W = 31;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	typedef enum logic [1:0] {
		OP_BAG   = 2'd0,
		OP_INDEX = 2'd1,
		OP_FINAL = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_FATAL  = 2'd0,
		MODE_WARN   = 2'd1,
		MODE_IGNORE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_CHECK_MODE  = 2'd0,
		REG_ROW_COUNT   = 2'd1,
		REG_INDEX_COUNT = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	// Running state that one item reads and rewrites.
	typedef struct packed {
		logic [VALUE_W-1:0] prev_end;
		logic [TALLY_W-1:0] tally;
		logic               stopped;
	} state_t;

	// Corrected item as it leaves the check logic.
	typedef struct packed {
		logic [VALUE_W-1:0] first;
		logic [VALUE_W-1:0] second;
		logic               bad;
	} result_t;

endpackage

/* rtl/ebc_check.sv */
// Bounds check and repair of one item, with the next running state.
module ebc_check (
	input  ebc_pkg::op_t                   operation,
	input  logic [ebc_pkg::VALUE_W-1:0]    first_value,
	input  logic [ebc_pkg::VALUE_W-1:0]    second_value,
	input  logic                           chain_start,
	input  ebc_pkg::mode_t                 mode,
	input  logic [ebc_pkg::COUNT_W-1:0]    row_count,
	input  logic [ebc_pkg::COUNT_W-1:0]    index_count,
	input  ebc_pkg::state_t                state,
	output ebc_pkg::result_t               result,
	output ebc_pkg::state_t                state_next
);

	localparam int unsigned VW = ebc_pkg::VALUE_W;
	localparam int unsigned PAD = ebc_pkg::VALUE_W - ebc_pkg::COUNT_W;

	logic signed [VW-1:0] limit;
	logic signed [VW-1:0] rows;
	logic signed [VW-1:0] bag_start;
	logic signed [VW-1:0] bag_end;
	logic signed [VW-1:0] start_fix;
	logic signed [VW-1:0] end_min;
	logic signed [VW-1:0] end_fix;
	logic signed [VW-1:0] idx;
	logic                 bag_bad;
	logic                 idx_bad;
	logic                 fin_bad;
	logic                 bad;
	logic                 repair;

	assign limit     = $signed({{PAD{1'b0}}, index_count});
	assign rows      = $signed({{PAD{1'b0}}, row_count});
	assign bag_start = chain_start ? $signed(state.prev_end) : $signed(first_value);
	assign bag_end   = $signed(second_value);
	assign idx       = $signed(first_value);

	assign bag_bad = (bag_start < 0) || (bag_start > bag_end) || (bag_end > limit);
	// An index of minus one marks a pruned row and always passes.
	assign idx_bad = (idx != -64'sd1) && ((idx < 0) || (idx >= rows));
	assign fin_bad = (idx != limit);

	// Clamp the start into [0, limit], then the end into [start, limit].
	assign start_fix = (bag_start < 0) ? '0 : ((bag_start > limit) ? limit : bag_start);
	assign end_min   = (bag_end > limit) ? limit : bag_end;
	assign end_fix   = (end_min < start_fix) ? start_fix : end_min;

	always_comb begin
		case (operation)
			ebc_pkg::OP_BAG: begin
				bad = bag_bad;
			end
			ebc_pkg::OP_INDEX: begin
				bad = idx_bad;
			end
			ebc_pkg::OP_FINAL: begin
				bad = fin_bad;
			end
			default: begin
				bad = 1'b0;
			end
		endcase
	end

	assign repair = bad && ((mode == ebc_pkg::MODE_WARN) || (mode == ebc_pkg::MODE_IGNORE));

	always_comb begin
		result     = '0;
		state_next = state;
		case (operation)
			ebc_pkg::OP_BAG: begin
				result.first  = repair ? start_fix : bag_start;
				result.second = repair ? end_fix : bag_end;
				state_next.prev_end = result.second;
			end
			ebc_pkg::OP_INDEX: begin
				result.first = repair ? '0 : idx;
			end
			ebc_pkg::OP_FINAL: begin
				result.first = repair ? limit : idx;
			end
			default: begin
				result.first = '0;
			end
		endcase
		result.bad = bad;

		if (bad && (mode == ebc_pkg::MODE_FATAL)) begin
			state_next.stopped = 1'b1;
		end
		if (bad && (mode == ebc_pkg::MODE_WARN) && (state.tally != ebc_pkg::TALLY_MAX)) begin
			state_next.tally = state.tally + 1'b1;
		end
	end

endmodule

/* rtl/embedding_index_bounds_check.sv */
// Top level of the embedding index bounds checker.
// An accepted item passes the input register, the check logic and the result register.
// One item per cycle while out_ready does not stall the result register;
// the chained bag start is resolved within the check stage.
// Reset (arst_n low, asynchronous) clears valid flags, registers and running state to zero.
// Configuration writes are taken in any cycle and land in the next.
module embedding_index_bounds_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [ebc_pkg::COUNT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [ebc_pkg::VALUE_W-1:0]   first_value,
	input  logic [ebc_pkg::VALUE_W-1:0]   second_value,
	input  logic                          chain_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ebc_pkg::VALUE_W-1:0]   out_first,
	output logic [ebc_pkg::VALUE_W-1:0]   out_second,
	output logic                          out_of_bounds,
	output logic [ebc_pkg::TALLY_W-1:0]   warnings_so_far,
	output logic                          fatal_stop
);

	ebc_pkg::mode_t                mode_q;
	logic [ebc_pkg::COUNT_W-1:0]   rows_q;
	logic [ebc_pkg::COUNT_W-1:0]   limit_q;
	ebc_pkg::state_t               state_q;
	ebc_pkg::state_t               state_next;
	ebc_pkg::result_t              result;

	logic                          valid_s1;
	ebc_pkg::op_t                  op_s1;
	logic [ebc_pkg::VALUE_W-1:0]   first_s1;
	logic [ebc_pkg::VALUE_W-1:0]   second_s1;
	logic                          chain_s1;

	logic                          valid_s2;
	ebc_pkg::result_t              result_s2;
	ebc_pkg::state_t               status_s2;

	logic                          advance;
	logic                          fire_s1;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign fire_s1   = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ebc_pkg::MODE_FATAL;
			rows_q  <= '0;
			limit_q <= '0;
		end else if (cfg_valid) begin
			unique case (ebc_pkg::reg_idx_t'(cfg_index))
				ebc_pkg::REG_CHECK_MODE:  mode_q  <= ebc_pkg::mode_t'(cfg_data[1:0]);
				ebc_pkg::REG_ROW_COUNT:   rows_q  <= cfg_data;
				ebc_pkg::REG_INDEX_COUNT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1     <= ebc_pkg::OP_BAG;
			first_s1  <= '0;
			second_s1 <= '0;
			chain_s1  <= 1'b0;
		end else if (in_valid && in_ready) begin
			op_s1     <= ebc_pkg::op_t'(operation);
			first_s1  <= first_value;
			second_s1 <= second_value;
			chain_s1  <= chain_start;
		end
	end

	ebc_check u_check (
		.operation    (op_s1),
		.first_value  (first_s1),
		.second_value (second_s1),
		.chain_start  (chain_s1),
		.mode         (mode_q),
		.row_count    (rows_q),
		.index_count  (limit_q),
		.state        (state_q),
		.result       (result),
		.state_next   (state_next)
	);

	// Running state commits together with the result, so the next item sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			valid_s2  <= 1'b0;
			status_s2 <= '0;
			result_s2 <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				state_q   <= state_next;
				status_s2 <= state_next;
				result_s2 <= result;
			end
		end
	end

	assign out_valid       = valid_s2;
	assign out_first       = result_s2.first;
	assign out_second      = result_s2.second;
	assign out_of_bounds   = result_s2.bad;
	assign warnings_so_far = status_s2.tally;
	assign fatal_stop      = status_s2.stopped;

endmodule

/* rtl/ebc_checker.sv */
// Port-level assertions for the embedding index bounds checker, bound to the top level.
module ebc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ebc_pkg::VALUE_W-1:0]   out_first,
	input logic [ebc_pkg::VALUE_W-1:0]   out_second,
	input logic                          out_of_bounds,
	input logic [ebc_pkg::TALLY_W-1:0]   warnings_so_far,
	input logic                          fatal_stop
);

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second)
			&& $stable(out_of_bounds))
		else $error("stalled result beat changed");

	// The stop flag is sticky until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		fatal_stop |=> fatal_stop)
		else $error("fatal stop flag dropped");

	// The warning count never goes down.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> warnings_so_far >= $past(warnings_so_far))
		else $error("warning count decreased");

	// At most one warning is added per result beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (warnings_so_far == $past(warnings_so_far))
			|| (warnings_so_far == $past(warnings_so_far) + 1'b1))
		else $error("warning count jumped");

endmodule

bind embedding_index_bounds_check ebc_checker u_ebc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.out_first       (out_first),
	.out_second      (out_second),
	.out_of_bounds   (out_of_bounds),
	.warnings_so_far (warnings_so_far),
	.fatal_stop      (fatal_stop)
);

/* tb/sv/embedding_index_bounds_check_tb.sv */
// Self-checking testbench for the embedding index bounds checker.
`timescale 1ns / 100ps

module embedding_index_bounds_check_tb;
	import ebc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [VALUE_W-1:0] first;
		logic [VALUE_W-1:0] second;
		logic               oob;
		logic [TALLY_W-1:0] warnings;
		logic               stop;
	} checked_item_t;

	class bounds_scoreboard;
		mode_t              mode;
		logic [COUNT_W-1:0] row_cnt;
		logic [COUNT_W-1:0] index_cnt;
		logic [VALUE_W-1:0] prev_end;
		logic [TALLY_W-1:0] tally;
		logic               stopped;
		checked_item_t      corrected_q[$];
		int                 mismatches;

		function new();
			mode = MODE_FATAL;
			row_cnt = '0;
			index_cnt = '0;
			prev_end = '0;
			tally = '0;
			stopped = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [COUNT_W-1:0] data);
			case (idx)
			REG_CHECK_MODE:  mode = mode_t'(data[1:0]);
			REG_ROW_COUNT:   row_cnt = data;
			REG_INDEX_COUNT: index_cnt = data;
			default: ;
			endcase
		endfunction

		// Applies the check mode to a violation and tells whether the value is repaired.
		function bit repairs_error();
			case (mode)
			MODE_FATAL: begin
				stopped = 1'b1;
				return 1'b0;
			end
			MODE_WARN: begin
				if (tally != TALLY_MAX)
					tally++;
				return 1'b1;
			end
			MODE_IGNORE: return 1'b1;
			default: return 1'b0;
			endcase
		endfunction

		function void accept_item(op_t op, logic [VALUE_W-1:0] f, logic [VALUE_W-1:0] s,
				logic chain);
			longint lim;
			longint rows;
			longint a;
			longint b;
			checked_item_t r;
			lim = index_cnt;
			rows = row_cnt;
			a = 0;
			b = 0;
			r.oob = 1'b0;
			case (op)
			OP_BAG: begin
				a = chain ? prev_end : f;
				b = s;
				if (a < 0 || a > b || b > lim) begin
					r.oob = 1'b1;
					if (repairs_error()) begin
						if (a > lim) a = lim;
						if (a < 0) a = 0;
						if (b > lim) b = lim;
						if (b < a) b = a;
					end
				end
				prev_end = b;
			end
			OP_INDEX: begin
				a = f;
				// A value of -1 marks a pruned row and always passes.
				if (a != -1 && (a < 0 || a >= rows)) begin
					r.oob = 1'b1;
					if (repairs_error())
						a = 0;
				end
			end
			OP_FINAL: begin
				a = f;
				if (a != lim) begin
					r.oob = 1'b1;
					if (repairs_error())
						a = lim;
				end
			end
			default: ;
			endcase
			r.first = a;
			r.second = b;
			r.warnings = tally;
			r.stop = stopped;
			corrected_q.push_back(r);
		endfunction

		function void note_mismatch(string what, logic [VALUE_W-1:0] want,
				logic [VALUE_W-1:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch in %s: expected %h, got %h", what, want, got);
		endfunction

		function void check_result(logic [VALUE_W-1:0] first, logic [VALUE_W-1:0] second,
				logic oob, logic [TALLY_W-1:0] warnings, logic stop);
			checked_item_t want;
			if (corrected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result beat with nothing expected: out_first %h", first);
				return;
			end
			want = corrected_q.pop_front();
			if (first !== want.first) note_mismatch("out_first", want.first, first);
			if (second !== want.second) note_mismatch("out_second", want.second, second);
			if (oob !== want.oob) note_mismatch("out_of_bounds", want.oob, oob);
			if (warnings !== want.warnings)
				note_mismatch("warnings_so_far", want.warnings, warnings);
			if (stop !== want.stop) note_mismatch("fatal_stop", want.stop, stop);
		endfunction

		function int pending();
			return corrected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	reg_idx_t           cfg_index = REG_CHECK_MODE;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	op_t                operation = OP_BAG;
	logic [VALUE_W-1:0] first_value = '0;
	logic [VALUE_W-1:0] second_value = '0;
	logic               chain_start = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] out_first;
	logic [VALUE_W-1:0] out_second;
	logic               out_of_bounds;
	logic [TALLY_W-1:0] warnings_so_far;
	logic               fatal_stop;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int sent = 0;

	bounds_scoreboard sb = new();

	embedding_index_bounds_check DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.first_value     (first_value),
		.second_value    (second_value),
		.chain_start     (chain_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_first       (out_first),
		.out_second      (out_second),
		.out_of_bounds   (out_of_bounds),
		.warnings_so_far (warnings_so_far),
		.fatal_stop      (fatal_stop)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_first, out_second, out_of_bounds, warnings_so_far, fatal_stop);
	end

	// The receiver stalls at random, and on request holds off for a long stretch.
	initial begin : receiver
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done < hold_requests) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else
				out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] pick_value(longint base);
		case ($urandom_range(9))
		0: return {$urandom, $urandom};
		1: return base;
		2: return base + 1;
		3: return base - 1;
		4: return '0;
		5: return '1;
		6: return {1'b1, 63'd0};
		7: return {1'b0, {63{1'b1}}};
		8: return $urandom_range(64);
		default: return -longint'($urandom_range(64, 1));
		endcase
	endfunction

	task automatic send_item(op_t op, logic [VALUE_W-1:0] f, logic [VALUE_W-1:0] s,
			logic chain);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		first_value <= f;
		second_value <= s;
		chain_start <= chain;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_item(op, f, s, chain);
		sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [COUNT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(mode_t mode, logic [COUNT_W-1:0] rows, logic [COUNT_W-1:0] icnt);
		wait_idle();
		write_reg(REG_CHECK_MODE, {30'd0, mode});
		write_reg(REG_ROW_COUNT, rows);
		write_reg(REG_INDEX_COUNT, icnt);
	endtask

	// A run of well-formed bags with their indices, closed by the final offset;
	// now and then one value is broken.
	task automatic send_bags();
		longint lim;
		longint rows;
		longint cur;
		longint nxt;
		longint idx;
		int bags;
		int k;
		int j;
		bit chain;
		lim = sb.index_cnt;
		rows = sb.row_cnt;
		if ($urandom_range(3) == 0)
			cur = lim - $urandom_range(16);
		else
			cur = $urandom_range(16);
		if (cur > lim) cur = lim;
		if (cur < 0) cur = 0;
		bags = $urandom_range(4, 1);
		for (k = 0; k < bags; k++) begin
			nxt = cur + $urandom_range(6);
			if (nxt > lim) nxt = lim;
			chain = (k > 0) && ($urandom_range(3) != 0);
			if ($urandom_range(11) == 0)
				send_item(OP_BAG, pick_value(cur), pick_value(lim), chain);
			else
				send_item(OP_BAG, chain ? pick_value(cur) : cur, nxt, chain);
			for (j = $urandom_range(3); j > 0; j--) begin
				if (rows == 0 || $urandom_range(5) == 0)
					idx = -1;
				else
					idx = $urandom_range(rows - 1);
				if ($urandom_range(11) == 0)
					idx = pick_value(rows);
				send_item(OP_INDEX, idx, {$urandom, $urandom}, $urandom_range(1) != 0);
			end
			cur = nxt;
		end
		send_item(OP_FINAL, ($urandom_range(9) == 0) ? pick_value(lim) : lim,
			{$urandom, $urandom}, $urandom_range(1) != 0);
	endtask

	task automatic send_noise();
		op_t op;
		op = op_t'($urandom_range(3));
		send_item(op, pick_value((op == OP_INDEX) ? sb.row_cnt : sb.index_cnt),
			pick_value(sb.index_cnt), $urandom_range(1) != 0);
	endtask

	task automatic run_phase(mode_t mode, logic [COUNT_W-1:0] rows, logic [COUNT_W-1:0] icnt,
			int idle, int stall, int count, bit pressure);
		int stop_at;
		configure(mode, rows, icnt);
		idle_pct = idle;
		stall_pct = stall;
		if (pressure)
			hold_requests++;
		stop_at = sent + count;
		while (sent < stop_at) begin
			if ($urandom_range(99) < 65)
				send_bags();
			else
				send_noise();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		configure(MODE_WARN, 10, 20);
		write_reg(REG_NONE, $urandom);
		send_item(OP_BAG, 0, 5, 1'b0);
		send_item(OP_BAG, 64'd99, 9, 1'b1);
		send_item(OP_BAG, -1, 3, 1'b0);
		send_item(OP_BAG, 7, 4, 1'b0);
		send_item(OP_BAG, 3, 21, 1'b0);
		send_item(OP_BAG, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 1'b0);
		send_item(OP_BAG, 0, 20, 1'b1);
		send_item(OP_INDEX, 0, '1, 1'b1);
		send_item(OP_INDEX, 9, 0, 1'b0);
		send_item(OP_INDEX, 10, 0, 1'b0);
		send_item(OP_INDEX, -1, 0, 1'b0);
		send_item(OP_INDEX, -2, 0, 1'b0);
		send_item(OP_INDEX, {1'b1, 63'd0}, 0, 1'b0);
		send_item(OP_INDEX, {1'b0, {63{1'b1}}}, 0, 1'b0);
		send_item(OP_FINAL, 20, '1, 1'b0);
		send_item(OP_FINAL, 21, 0, 1'b1);
		send_item(OP_FINAL, -1, 0, 1'b0);
		send_item(OP_NONE, '1, '1, 1'b1);

		configure(MODE_IGNORE, 10, 20);
		send_item(OP_INDEX, 10, 0, 1'b0);
		send_item(OP_BAG, 25, 30, 1'b0);

		// The unused mode reports violations without repairing or counting them.
		configure(MODE_NONE, 10, 20);
		send_item(OP_INDEX, 10, 0, 1'b0);
		send_item(OP_FINAL, 0, 0, 1'b0);

		run_phase(MODE_WARN, 16, 40, 0, 0, 300, 1'b0);
		run_phase(MODE_IGNORE, 1, 0, 77, 0, 220, 1'b0);
		run_phase(MODE_WARN, '1, '1, 0, 77, 220, 1'b0);
		run_phase(MODE_NONE, 0, 7, 14, 14, 180, 1'b0);
		run_phase(MODE_IGNORE, $urandom_range(300, 1), $urandom_range(300, 1), 14, 14, 200,
			1'b1);

		// Fatal mode comes last since its stop flag stays set until reset.
		idle_pct = 0;
		stall_pct = 0;
		configure(MODE_FATAL, 5, 100);
		send_item(OP_INDEX, 3, 0, 1'b0);
		send_item(OP_BAG, 8, 2, 1'b0);
		send_item(OP_INDEX, 5, 0, 1'b0);
		send_item(OP_FINAL, 100, 0, 1'b0);
		send_item(OP_NONE, 0, 0, 1'b0);
		run_phase(MODE_FATAL, 5, 100, 30, 30, 300, 1'b1);

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* embedding_index_bounds_check.f */
rtl/ebc_pkg.sv
rtl/ebc_check.sv
rtl/embedding_index_bounds_check.sv
rtl/ebc_checker.sv
tb/sv/embedding_index_bounds_check_tb.sv
